// ----- rtl/wsg_pkg.sv -----
package wsg_pkg;

   localparam int SAMPLE_W = 16;
   localparam int FILT_W   = 24;
   localparam int DERIV_W  = 26;
   localparam int IDX_W    = 8;
   localparam int SHIFT_W  = 3;
   localparam int THRESH_W = 17;
   localparam int CSR_IDX_W = 1;
   localparam int CLASS_W  = 2;
   localparam int GEST_W   = 2;

   typedef logic signed [FILT_W-1:0]  filt_type;
   typedef logic signed [DERIV_W-1:0] deriv_type;
   typedef logic [IDX_W-1:0]          idx_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_SHIFT     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE_THRESHOLD = 1'd1;

   localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 3'd2;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd5;

   localparam logic [CLASS_W-1:0] CLS_SMALL       = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_MAX_FIRST   = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_MAX_NOT_FIRST = 2'd2;

   localparam logic [GEST_W-1:0] GS_INIT = 2'd0;
   localparam logic [GEST_W-1:0] GS_HIGH = 2'd1;
   localparam logic [GEST_W-1:0] GS_LOW  = 2'd2;
   localparam logic [GEST_W-1:0] GS_DONE = 2'd3;

   typedef struct packed {
      logic      has_a;
      logic      first;
      deriv_type da;
      idx_type   ia;
      logic      last;
      deriv_type db;
      idx_type   ib;
   } deriv_rec_type;

   typedef struct packed {
      logic [CLASS_W-1:0] swing_class;
      logic [GEST_W-1:0]  gesture_state;
   } result_type;

endpackage

// ----- rtl/wsg_fifo.sv -----
module wsg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/wsg_front.sv -----
module wsg_front
   import wsg_pkg::*;
#(
   parameter int WINDOW = 25
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic [SHIFT_W-1:0]         smoothing_shift,
   output deriv_rec_type              rec
);

   localparam idx_type LAST_IDX = IDX_W'(WINDOW - 1);

   filt_type                 y_ff, y_in;
   filt_type                 yprev_ff, yprev_in;
   idx_type                  count_ff, count_in;
   filt_type                 xq;
   logic signed [FILT_W:0]   diff;
   logic signed [FILT_W:0]   step;
   filt_type                 ynew;
   logic signed [FILT_W:0]   dcur;
   logic signed [FILT_W:0]   dcent;
   deriv_type                dbl;
   logic                     last;

   always_comb begin
      xq    = {sample, 8'b0};
      diff  = {xq[FILT_W-1], xq} - {y_ff[FILT_W-1], y_ff};
      step  = diff >>> smoothing_shift;
      ynew  = (count_ff == '0) ? xq : y_ff + step[FILT_W-1:0];
      dcur  = {ynew[FILT_W-1], ynew} - {y_ff[FILT_W-1], y_ff};
      dcent = {ynew[FILT_W-1], ynew} - {yprev_ff[FILT_W-1], yprev_ff};
      dbl   = {dcur, 1'b0};
      last  = (count_ff >= LAST_IDX);

      rec.has_a = (count_ff != '0);
      rec.first = (count_ff == IDX_W'(1));
      rec.da    = rec.first ? dbl : {dcent[FILT_W], dcent};
      rec.ia    = count_ff - 1'b1;
      rec.last  = last;
      rec.db    = dbl;
      rec.ib    = count_ff;

      y_in     = y_ff;
      yprev_in = yprev_ff;
      count_in = count_ff;
      if (accept) begin
         y_in     = ynew;
         yprev_in = y_ff;
         count_in = last ? '0 : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_ff     <= '0;
         yprev_ff <= '0;
         count_ff <= '0;
      end else begin
         y_ff     <= y_in;
         yprev_ff <= yprev_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/wsg_back.sv -----
module wsg_back
   import wsg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  deriv_rec_type       rec,
   input  logic                rec_valid,
   output logic                rec_pop,
   input  logic [THRESH_W-1:0] amplitude_threshold,
   input  logic                out_full,
   output logic                out_push,
   output result_type          out_data
);

   deriv_type               max_ff, max_in;
   deriv_type               min_ff, min_in;
   idx_type                 max_idx_ff, max_idx_in;
   idx_type                 min_idx_ff, min_idx_in;
   logic [GEST_W-1:0]       gest_ff, gest_in;
   logic                    pend_ff, pend_in;
   logic [DERIV_W:0]        swing;
   logic [DERIV_W:0]        thresh_scaled;
   logic [CLASS_W-1:0]      cls;
   logic [GEST_W-1:0]       gest_next;

   assign rec_pop  = rec_valid && !(pend_ff && out_full);
   assign out_push = pend_ff && !out_full;

   always_comb begin
      max_in     = max_ff;
      min_in     = min_ff;
      max_idx_in = max_idx_ff;
      min_idx_in = min_idx_ff;
      if (rec_pop && rec.has_a) begin
         if (rec.first) begin
            max_in     = rec.da;
            min_in     = rec.da;
            max_idx_in = '0;
            min_idx_in = '0;
         end else begin
            if (rec.da > max_in) begin
               max_in     = rec.da;
               max_idx_in = rec.ia;
            end
            if (rec.da < min_in) begin
               min_in     = rec.da;
               min_idx_in = rec.ia;
            end
         end
      end
      if (rec_pop && rec.last) begin
         if (rec.db > max_in) begin
            max_in     = rec.db;
            max_idx_in = rec.ib;
         end
         if (rec.db < min_in) begin
            min_in     = rec.db;
            min_idx_in = rec.ib;
         end
      end
   end

   always_comb begin
      swing         = {max_ff[DERIV_W-1], max_ff} - {min_ff[DERIV_W-1], min_ff};
      thresh_scaled = {1'b0, amplitude_threshold, 9'b0};
      priority if (swing < thresh_scaled) begin
         cls = CLS_SMALL;
      end else if (max_idx_ff < min_idx_ff) begin
         cls = CLS_MAX_FIRST;
      end else begin
         cls = CLS_MAX_NOT_FIRST;
      end

      unique case (gest_ff)
         GS_INIT: begin
            gest_next = (cls == CLS_MAX_NOT_FIRST) ? GS_HIGH : GS_INIT;
         end
         GS_HIGH: begin
            gest_next = (cls == CLS_SMALL) ? GS_INIT :
                        (cls == CLS_MAX_FIRST) ? GS_LOW : GS_HIGH;
         end
         GS_LOW: begin
            gest_next = (cls == CLS_MAX_NOT_FIRST) ? GS_INIT :
                        (cls == CLS_SMALL) ? GS_DONE : GS_LOW;
         end
         default: begin
            gest_next = GS_INIT;
         end
      endcase

      out_data.swing_class   = cls;
      out_data.gesture_state = gest_next;
      gest_in = out_push ? gest_next : gest_ff;
      pend_in = (pend_ff && out_full) || (rec_pop && rec.last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff     <= '0;
         min_ff     <= '0;
         max_idx_ff <= '0;
         min_idx_ff <= '0;
         gest_ff    <= GS_INIT;
         pend_ff    <= 1'b0;
      end else begin
         max_ff     <= max_in;
         min_ff     <= min_in;
         max_idx_ff <= max_idx_in;
         min_idx_ff <= min_idx_in;
         gest_ff    <= gest_in;
         pend_ff    <= pend_in;
      end
   end

endmodule

// ----- rtl/window_swing_gesture_detector.sv -----
// Window swing gesture detector.
// Input channel: req_push/req_full with req_sample, one signed sample per transfer.
// Samples are grouped into windows of WINDOW samples; the filter restarts at
// each window. Only the last sample of a window yields a result.
// Result channel: rsp_empty/rsp_pop with rsp_swing_class and
// rsp_gesture_state; the oldest result shows while rsp_empty is low.
// Config channel: csr_valid/csr_ready (always ready) with csr_index, csr_data;
// index 0 is the smoothing shift, index 1 the amplitude threshold. Write only
// while idle.
// Throughput: one sample per cycle while req_full is low. The filter and
// derivative run in the accept cycle and the derivative record is queued;
// the extremes update when the record is popped, and the class and gesture
// step follow from the registered extremes as the result is queued.
// Reset clears the filter, window count, extremes, gesture state and both
// queues, and loads shift 2 and threshold 5.
// When the receiver stalls, the result queue fills, the record queue backs up
// and req_full rises; nothing is dropped.
module window_swing_gesture_detector
   import wsg_pkg::*;
#(
   parameter int WINDOW = 25
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [CLASS_W-1:0]         rsp_swing_class,
   output logic [GEST_W-1:0]          rsp_gesture_state,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [THRESH_W-1:0]        csr_data
);

   logic [SHIFT_W-1:0]  shift_ff, shift_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic                accept;
   deriv_rec_type       front_rec;
   deriv_rec_type       back_rec;
   logic                rec_empty, rec_pop;
   logic                out_full, out_push;
   result_type          out_data, rsp_data;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   always_comb begin
      shift_in  = shift_ff;
      thresh_in = thresh_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SMOOTHING_SHIFT:     shift_in  = csr_data[SHIFT_W-1:0];
            CSR_AMPLITUDE_THRESHOLD: thresh_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= SHIFT_RESET;
         thresh_ff <= THRESH_RESET;
      end else begin
         shift_ff  <= shift_in;
         thresh_ff <= thresh_in;
      end
   end

   wsg_front #(.WINDOW(WINDOW)) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .sample          (req_sample),
      .smoothing_shift (shift_ff),
      .rec             (front_rec)
   );

   wsg_fifo #(.WIDTH($bits(deriv_rec_type)), .DEPTH(2)) u_rec_q (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_rec),
      .full      (req_full),
      .pop       (rec_pop),
      .pop_data  (back_rec),
      .empty     (rec_empty)
   );

   wsg_back u_back (
      .clock               (clock),
      .reset               (reset),
      .rec                 (back_rec),
      .rec_valid           (!rec_empty),
      .rec_pop             (rec_pop),
      .amplitude_threshold (thresh_ff),
      .out_full            (out_full),
      .out_push            (out_push),
      .out_data            (out_data)
   );

   wsg_fifo #(.WIDTH($bits(result_type)), .DEPTH(2)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   assign rsp_swing_class   = rsp_data.swing_class;
   assign rsp_gesture_state = rsp_data.gesture_state;

endmodule

// ----- rtl/wsg_checker.sv -----
module wsg_checker
   import wsg_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic [CLASS_W-1:0] rsp_swing_class,
   input logic [GEST_W-1:0]  rsp_gesture_state
);

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_class_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_swing_class <= CLS_MAX_NOT_FIRST))
      else $error("undefined swing class");

   a_high_from_late_max: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_gesture_state == GS_HIGH) |-> rsp_swing_class == CLS_MAX_NOT_FIRST)
      else $error("high state without late max");

   a_done_from_small: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_gesture_state == GS_DONE) |-> rsp_swing_class == CLS_SMALL)
      else $error("done state without small swing");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_swing_class) && $stable(rsp_gesture_state)))
      else $error("stalled result changed");

endmodule

bind window_swing_gesture_detector wsg_checker u_wsg_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_swing_class   (rsp_swing_class),
   .rsp_gesture_state (rsp_gesture_state)
);
